### design/bounded_ordered_list_engine_macros.svh
// Assertion macros shared by the bounded ordered list engine.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// A property that must hold at every clock edge.
`define BOLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A condition that must be followed by a consequence in the same cycle.
`define BOLE_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define BOLE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### design/bole_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Operation, status and state codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_ORD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DEL_VAL   = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_INS_ORD,
    OP_DEL_FRONT,
    OP_DEL_BACK,
    OP_DEL_VAL
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic                      valid;
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] carry;
    logic                      hit;
  } tok_t;

  function automatic logic is_insert(input op_t op);
    is_insert = (op == OP_INS_FRONT) || (op == OP_INS_BACK) || (op == OP_INS_ORD);
  endfunction

  function automatic logic is_delete(input op_t op);
    is_delete = (op == OP_DEL_FRONT) || (op == OP_DEL_BACK) || (op == OP_DEL_VAL);
  endfunction

endpackage
`default_nettype wire

### design/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_ordered_list_engine_macros.svh"
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// A row of list cells updated by an operation token that walks from the head.
//
//   Channel  Ports                                            Beat
//   in       in_valid in_ready in_kind in_value               operation in
//   out      out_valid out_ready out_status out_entry_count   status out
//
// Each operation is registered as a token in the launch register and steps
// one cell per cycle through the chain before its result is registered out.
// A new beat is taken only after the previous result has been registered on
// the result side; only one operation is in the chain at a time.
// A stalled result is parked in a holding register and blocks new beats.
// Reset empties the list; entry storage itself is not cleared.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [COUNT_W-1:0]         out_entry_count
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

  state_t                    state_r, state_nxt;
  logic [OCC_W-1:0]          occ_r, occ_nxt;
  logic [STATUS_W-1:0]       pre_status_r, pre_status_nxt;
  tok_t                      launch_r, launch_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic [STATUS_W-1:0]       hold_status_r, hold_status_nxt;
  logic [COUNT_W-1:0]        hold_count_r, hold_count_nxt;

  tok_t                      tok_w [0:CAPACITY];
  logic signed [VALUE_W-1:0] entry_w [0:CAPACITY-1];
  logic [CAPACITY-1:0]       tok_busy;

  tok_t                      last_tok;
  logic                      in_fire;
  logic                      out_free;
  logic                      full;
  logic                      empty;
  logic [STATUS_W-1:0]       fin_status;
  logic [OCC_W-1:0]          fin_occ;
  logic [OCC_W+COUNT_W-1:0]  fin_ext;
  logic [COUNT_W-1:0]        fin_count;
  op_t                       start_op;
  logic [STATUS_W-1:0]       start_status;

  assign tok_w[0] = launch_r;
  assign last_tok = tok_w[CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [VALUE_W-1:0] next_entry;
      if (gi == CAPACITY - 1) begin : g_tail
        assign next_entry = entry_w[gi];
      end else begin : g_body
        assign next_entry = entry_w[gi+1];
      end
      bole_cell #(
        .IDX   (gi),
        .OCC_W (OCC_W)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .occ_i        (occ_r),
        .next_entry_i (next_entry),
        .tok_i        (tok_w[gi]),
        .entry_o      (entry_w[gi]),
        .tok_o        (tok_w[gi+1])
      );
      assign tok_busy[gi] = tok_w[gi].valid;
    end
  endgenerate

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign full     = occ_r >= OCC_W'(CAPACITY);
  assign empty    = occ_r == '0;

  always_comb begin
    start_op     = OP_NOP;
    start_status = STAT_DONE;
    case (in_kind)
      KIND_INS_FRONT: begin
        start_op     = full ? OP_NOP : OP_INS_FRONT;
        start_status = full ? STAT_FULL : STAT_DONE;
      end
      KIND_INS_BACK: begin
        start_op     = full ? OP_NOP : OP_INS_BACK;
        start_status = full ? STAT_FULL : STAT_DONE;
      end
      KIND_INS_ORD: begin
        start_op     = full ? OP_NOP : OP_INS_ORD;
        start_status = full ? STAT_FULL : STAT_DONE;
      end
      KIND_DEL_FRONT: begin
        start_op     = empty ? OP_NOP : OP_DEL_FRONT;
        start_status = empty ? STAT_EMPTY : STAT_DONE;
      end
      KIND_DEL_BACK: begin
        start_op     = empty ? OP_NOP : OP_DEL_BACK;
        start_status = empty ? STAT_EMPTY : STAT_DONE;
      end
      KIND_DEL_VAL: begin
        start_op     = empty ? OP_NOP : OP_DEL_VAL;
        start_status = empty ? STAT_EMPTY : STAT_DONE;
      end
      default: begin
        start_op     = OP_NOP;
        start_status = STAT_DONE;
      end
    endcase
  end

  always_comb begin
    fin_status = pre_status_r;
    if (pre_status_r == STAT_DONE && last_tok.op == OP_DEL_VAL && !last_tok.hit) begin
      fin_status = STAT_NOT_FOUND;
    end
    fin_occ = occ_r;
    if (last_tok.hit && is_insert(last_tok.op)) begin
      fin_occ = occ_r + OCC_W'(1);
    end else if (last_tok.hit && is_delete(last_tok.op)) begin
      fin_occ = occ_r - OCC_W'(1);
    end
    fin_ext   = (OCC_W + COUNT_W)'(fin_occ);
    fin_count = fin_ext[COUNT_W-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    occ_nxt         = occ_r;
    pre_status_nxt  = pre_status_r;
    launch_nxt      = '0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    hold_status_nxt = hold_status_r;
    hold_count_nxt  = hold_count_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          launch_nxt.valid = 1'b1;
          launch_nxt.op    = start_op;
          launch_nxt.value = in_value;
          pre_status_nxt   = start_status;
          state_nxt        = S_WALK;
        end
      end
      S_WALK: begin
        if (last_tok.valid) begin
          occ_nxt = fin_occ;
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fin_status;
            out_count_nxt  = fin_count;
            state_nxt      = S_IDLE;
          end else begin
            hold_status_nxt = fin_status;
            hold_count_nxt  = fin_count;
            state_nxt       = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = hold_status_r;
          out_count_nxt  = hold_count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pre_status_r  <= pre_status_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    hold_status_r <= hold_status_nxt;
    hold_count_r  <= hold_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  `BOLE_ASSERT(a_occ_bound, occ_r <= OCC_W'(CAPACITY), "Occupancy exceeds capacity.")
  `BOLE_ASSERT(a_one_token, $onehot0({tok_busy, last_tok.valid}), "More than one token in chain.")
  `BOLE_ASSERT_NEXT(a_launch, in_fire, launch_r.valid && state_r == S_WALK, "Beat not launched.")
  `BOLE_ASSERT_IMP(a_tok_walk, tok_busy != '0 || last_tok.valid, state_r == S_WALK,
                   "Token in chain outside of walk.")

endmodule
`default_nettype wire

### design/bole_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded ordered list engine cell
// Holds one list position and applies the passing operation token to it.
// ----------------------------------------------------------------------------
module bole_cell
  import bole_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned OCC_W = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [OCC_W-1:0]          occ_i,
  input  logic signed [VALUE_W-1:0] next_entry_i,
  input  tok_t                      tok_i,
  output logic signed [VALUE_W-1:0] entry_o,
  output tok_t                      tok_o
);

  logic signed [VALUE_W-1:0] entry_r, entry_nxt;
  tok_t                      tok_r, tok_nxt;
  logic                      valid_here;
  logic                      at_end;
  logic                      last_here;
  logic                      ins_here;
  logic                      del_here;

  always_comb begin
    valid_here = OCC_W'(IDX) < occ_i;
    at_end     = OCC_W'(IDX) == occ_i;
    last_here  = OCC_W'(IDX + 1) == occ_i;
    ins_here   = 1'b0;
    del_here   = 1'b0;
    case (tok_i.op)
      OP_INS_FRONT: ins_here = (IDX == 0);
      OP_INS_BACK:  ins_here = at_end;
      OP_INS_ORD: begin
        if (IDX == 0) begin
          ins_here = at_end || (tok_i.value <= entry_r);
        end else begin
          ins_here = at_end || (valid_here && (entry_r > tok_i.value));
        end
      end
      OP_DEL_FRONT: del_here = valid_here && (IDX == 0);
      OP_DEL_BACK:  del_here = last_here;
      OP_DEL_VAL:   del_here = valid_here && (entry_r == tok_i.value);
      default: begin
        ins_here = 1'b0;
        del_here = 1'b0;
      end
    endcase
  end

  always_comb begin
    entry_nxt = entry_r;
    tok_nxt   = tok_i;
    if (tok_i.valid) begin
      if (is_insert(tok_i.op)) begin
        if (!tok_i.hit && ins_here) begin
          entry_nxt     = tok_i.value;
          tok_nxt.carry = entry_r;
          tok_nxt.hit   = 1'b1;
        end else if (tok_i.hit && (valid_here || at_end)) begin
          entry_nxt     = tok_i.carry;
          tok_nxt.carry = entry_r;
        end
      end else if (is_delete(tok_i.op)) begin
        if ((!tok_i.hit && del_here) || (tok_i.hit && valid_here)) begin
          entry_nxt   = next_entry_i;
          tok_nxt.hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign entry_o = entry_r;
  assign tok_o   = tok_r;

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list engine testbench
// Sends list operations through the valid/ready input channel with random
// idle gaps and output stalls. It keeps its own copy of the list, predicts
// the status and entry count of every beat, and checks each result beat
// against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb;
  import bole_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = LIST_DEPTH + 8;
  localparam int unsigned RANDOM_OPS   = 420;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [KIND_W-1:0]         in_kind = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic [COUNT_W-1:0]        out_entry_count;

  logic signed [VALUE_W-1:0] list_q[$];
  list_result_t              pending_results[$];
  int unsigned               mismatch_count = 0;
  int unsigned               cycle_count = 0;
  int unsigned               stall_left = 0;
  bit                        sender_steady = 1'b0;
  bit                        receiver_steady = 1'b0;

  bounded_ordered_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) begin
      v = $urandom_range(16);
      v = v - 32'sd8;
    end else if (r < 60 && list_q.size() > 0) begin
      v = list_q[$urandom_range(list_q.size() - 1)];
    end else if (r < 70) begin
      case ($urandom_range(3))
        0: v = VALUE_MIN;
        1: v = VALUE_MAX;
        2: v = '0;
        default: v = -32'sd1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic apply_to_list(input logic [KIND_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] value);
    list_result_t res;
    int           slot;
    bit           found;
    res.status = STAT_DONE;
    case (kind)
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_ORD: begin
        if (list_q.size() >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else if (kind == KIND_INS_FRONT) begin
          list_q.push_front(value);
        end else if (kind == KIND_INS_BACK) begin
          list_q.push_back(value);
        end else begin
          slot = list_q.size();
          if (list_q.size() == 0 || value <= list_q[0]) begin
            slot = 0;
          end else begin
            for (int i = 1; i < list_q.size(); i++) begin
              if (list_q[i] > value && slot == list_q.size()) slot = i;
            end
          end
          if (slot == list_q.size()) list_q.push_back(value);
          else list_q.insert(slot, value);
        end
      end
      KIND_DEL_FRONT, KIND_DEL_BACK: begin
        if (list_q.size() == 0) res.status = STAT_EMPTY;
        else if (kind == KIND_DEL_FRONT) void'(list_q.pop_front());
        else void'(list_q.pop_back());
      end
      KIND_DEL_VAL: begin
        if (list_q.size() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          found = 1'b0;
          for (int i = 0; i < list_q.size() && !found; i++) begin
            if (list_q[i] == value) begin
              list_q.delete(i);
              found = 1'b1;
            end
          end
          res.status = found ? STAT_DONE : STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
    res.count = COUNT_W'(list_q.size());
    pending_results.push_back(res);
  endtask

  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic signed [VALUE_W-1:0] value);
    int unsigned gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    apply_to_list(kind, value);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_op(KIND_DEL_FRONT, VALUE_MAX);
    send_op(KIND_DEL_BACK, VALUE_MIN);
    send_op(KIND_DEL_VAL, '0);
  endtask

  task automatic test_spare_kinds();
    send_op(KIND_SPARE_LO, 32'sh5555_5555);
    send_op(KIND_SPARE_HI, 32'shaaaa_aaaa);
  endtask

  task automatic test_ordered_insert();
    send_op(KIND_INS_ORD, '0);
    send_op(KIND_INS_ORD, VALUE_MAX);
    send_op(KIND_INS_ORD, VALUE_MIN);
    send_op(KIND_INS_ORD, VALUE_MIN);
    send_op(KIND_INS_ORD, '0);
    send_op(KIND_INS_ORD, -32'sd1);
  endtask

  task automatic test_full_list();
    int unsigned n;
    n = 0;
    while (list_q.size() < LIST_DEPTH) begin
      case (n % 3)
        0: send_op(KIND_INS_FRONT, $urandom);
        1: send_op(KIND_INS_BACK, $urandom);
        default: send_op(KIND_INS_ORD, $urandom);
      endcase
      n++;
    end
    send_op(KIND_INS_FRONT, VALUE_MAX);
    send_op(KIND_INS_BACK, VALUE_MIN);
    send_op(KIND_INS_ORD, '0);
  endtask

  task automatic test_delete_ops();
    send_op(KIND_DEL_FRONT, $urandom);
    send_op(KIND_DEL_BACK, $urandom);
    send_op(KIND_DEL_VAL, list_q[list_q.size() / 2]);
    send_op(KIND_DEL_VAL, 32'sd7654321);
  endtask

  task automatic test_random_mix(input int unsigned n_ops);
    int unsigned       sent;
    int unsigned       phase_left;
    int unsigned       insert_pct;
    int unsigned       r;
    logic [KIND_W-1:0] kind;
    sent = 0;
    phase_left = 0;
    insert_pct = 50;
    while (sent < n_ops) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 10);
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
        sender_steady   = ($urandom_range(3) == 0);
        receiver_steady = ($urandom_range(3) == 0);
        if ($urandom_range(4) == 0) wait_for_results();
      end
      r = $urandom_range(99);
      if (r < 2) begin
        kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      end else if (r < insert_pct) begin
        case ($urandom_range(2))
          0: kind = KIND_INS_FRONT;
          1: kind = KIND_INS_BACK;
          default: kind = KIND_INS_ORD;
        endcase
      end else begin
        case ($urandom_range(3))
          0: kind = KIND_DEL_FRONT;
          1: kind = KIND_DEL_BACK;
          default: kind = KIND_DEL_VAL;
        endcase
      end
      send_op(kind, pick_value());
      if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI) sent++;
      phase_left--;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!receiver_steady && $urandom_range(2) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (status %0d count %0d)",
                                  out_status, out_entry_count));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_entry_count !== want.count)
          report_mismatch($sformatf("entry count %0d, expected %0d",
                                    out_entry_count, want.count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_spare_kinds();
    wait_for_results();
    test_ordered_insert();
    test_full_list();
    wait_for_results();
    test_delete_ops();
    test_random_mix(RANDOM_OPS);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/bole_pkg.sv
design/bole_cell.sv
design/bounded_ordered_list_engine.sv
tb/tb.sv
